// ===== hw/rtl/lsvw_pkg.sv =====
// shared types, constants and helpers of the line segment voxel walk
`timescale 1ns / 1ps
`default_nettype none
package lsvw_pkg;

  // fixed field widths
  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 31;
  localparam int GRID_W   = 15;
  localparam int TIME_W   = 32;
  localparam int CELL_W   = 5;
  localparam int OUT_C_W  = 4;
  localparam int LIN_W    = 12;
  localparam int CFG_IDX_W = 3;

  // per-axis cap on voxel count
  localparam int MAX_AXIS_CELLS = 16;
  // defaults for top level parameters
  localparam int MAX_STEPS_DEF = 46;
  localparam int FRAC_BITS_DEF = 16;

  // quotient bits of the short division that finds a cell index
  localparam int SHORT_BITS = CELL_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COUNTS = 3'd6;

  // divider operation codes
  localparam logic [1:0] OP_START_CELL  = 2'd0;
  localparam logic [1:0] OP_FINISH_CELL = 2'd1;
  localparam logic [1:0] OP_DELTA       = 2'd2;
  localparam logic [1:0] OP_EXIT        = 2'd3;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic [1:0] axis;
    logic       div_go;
    logic [1:0] op;
    logic       mul_go;
    logic       set_dir;
    logic       zero_axis;
    logic       emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic d_zero;
    logic at_end;
    logic cnt_hit;
    logic out_free;
  } sts_t;

  // voxel count of one axis, zero acts as one, capped
  function automatic logic [CELL_W-1:0] axis_count(input logic [GRID_W-1:0] g,
                                                    input logic [1:0] a);
    logic [CELL_W-1:0] f;
    logic [CELL_W-1:0] n;
    begin
      case (a)
        AXIS_X:  f = g[4:0];
        AXIS_Y:  f = g[9:5];
        default: f = g[14:10];
      endcase
      n = f;
      if (f == '0) n = CELL_W'(1);
      if (int'(f) > MAX_AXIS_CELLS) n = CELL_W'(MAX_AXIS_CELLS);
      return n;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lsvw_div.sv =====
// shared restoring divider, one quotient bit per cycle, saturating
`timescale 1ns / 1ps
`default_nettype none
module lsvw_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire                         short_mode,
  input  wire  [NUM_W-1:0]            num,
  input  wire  [DEN_W-1:0]            den,
  output logic                        busy,
  output logic                        done,
  output logic [lsvw_pkg::TIME_W-1:0] quot,
  output logic                        sat
);
  import lsvw_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [TIME_W-1:0] lo;
  logic [5:0]        steps;
  logic [NUM_W-1:0]  hi;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W:0]    diff;

  // upper part of the numerator, must stay below the divisor
  always_comb begin
    hi    = short_mode ? (num >> SHORT_BITS) : (num >> TIME_W);
    trial = {rem, lo[TIME_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= short_mode ? 6'(SHORT_BITS) : 6'(TIME_W);
      end else if (busy) begin
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= hi[DEN_W-1:0];
      den_q <= den;
      sat   <= hi >= NUM_W'(den);
      quot  <= '0;
      lo    <= short_mode ? {num[SHORT_BITS-1:0], {(TIME_W-SHORT_BITS){1'b0}}}
                          : num[TIME_W-1:0];
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[TIME_W-2:0], ge};
      lo   <= {lo[TIME_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lsvw_datapath.sv =====
// datapath: config registers, setup arithmetic, walk state and output register
`timescale 1ns / 1ps
`default_nettype none
module lsvw_datapath #(
  parameter int FRAC_BITS = lsvw_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS = lsvw_pkg::MAX_STEPS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [lsvw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [lsvw_pkg::COORD_W-1:0]    cfg_data,
  input  wire  [lsvw_pkg::COORD_W-1:0]    start_x,
  input  wire  [lsvw_pkg::COORD_W-1:0]    start_y,
  input  wire  [lsvw_pkg::COORD_W-1:0]    start_z,
  input  wire  [lsvw_pkg::COORD_W-1:0]    finish_x,
  input  wire  [lsvw_pkg::COORD_W-1:0]    finish_y,
  input  wire  [lsvw_pkg::COORD_W-1:0]    finish_z,
  input  wire  lsvw_pkg::cmd_t            cmd,
  output lsvw_pkg::sts_t                  sts,
  input  wire                             out_ready,
  output logic                            out_valid,
  output logic [lsvw_pkg::OUT_C_W-1:0]    cell_x,
  output logic [lsvw_pkg::OUT_C_W-1:0]    cell_y,
  output logic [lsvw_pkg::OUT_C_W-1:0]    cell_z,
  output logic [lsvw_pkg::LIN_W-1:0]      linear_index,
  output logic                            last,
  output logic                            overrun
);
  import lsvw_pkg::*;

  localparam int DIST_W = COORD_W + 1;
  localparam int NUM_W  = DIST_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int PROD_W = CELL_W + SIZE_W;
  localparam int WIDE_W = PROD_W + 2;

  // configuration
  logic signed [COORD_W-1:0] amin [3];
  logic [SIZE_W-1:0]         csize [3];
  logic [GRID_W-1:0]         grid;

  // captured segment
  logic signed [COORD_W-1:0] p0 [3];
  logic signed [COORD_W-1:0] p1 [3];

  // walk state
  logic [CELL_W-1:0]   cur [3];
  logic [CELL_W-1:0]   tgt [3];
  logic                dpos [3];
  logic                dneg [3];
  logic [TIME_W-1:0]   ext [3];
  logic [TIME_W-1:0]   dlt [3];
  logic [CNT_W-1:0]    cnt;
  logic [1:0]          op_q;
  logic [2*CELL_W-1:0] nyz;
  logic [CELL_W-1:0]   nz;
  logic [PROD_W-1:0]   prod;
  logic [CELL_W-1:0]   nm1 [3];

  // selected-axis setup signals
  logic signed [COORD_W:0] rs;
  logic signed [COORD_W:0] rf;
  logic signed [COORD_W:0] d;
  logic [COORD_W-1:0]      ad;
  logic [SIZE_W-1:0]       sz;
  logic signed [WIDE_W-1:0] dr;
  logic signed [WIDE_W-1:0] dd;
  logic [DIST_W-1:0]       face_dist;
  logic [NUM_W-1:0]        div_num;
  logic [COORD_W-1:0]      div_den;
  logic                    div_short;
  logic                    div_busy;
  logic                    div_done;
  logic [TIME_W-1:0]       quot;
  logic                    sat;
  logic [TIME_W-1:0]       q_eff;
  logic [CELL_W-1:0]       cell_q;

  // walk step signals
  logic [1:0]          ws;
  logic [CELL_W-1:0]   cur_s;
  logic [CELL_W-1:0]   nc;
  logic [TIME_W:0]     exit_sum;
  logic                at_end;
  logic                cnt_hit;
  logic [15:0]         lin;

  // voxel count limits per axis
  always_comb begin
    nm1[0] = axis_count(grid, AXIS_X) - CELL_W'(1);
    nm1[1] = axis_count(grid, AXIS_Y) - CELL_W'(1);
    nm1[2] = axis_count(grid, AXIS_Z) - CELL_W'(1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        amin[a]  <= '0;
        csize[a] <= SIZE_W'(65536);
      end
      grid <= GRID_W'(16912);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_MIN_X:  amin[0] <= cfg_data;
        REG_AREA_MIN_Y:  amin[1] <= cfg_data;
        REG_AREA_MIN_Z:  amin[2] <= cfg_data;
        REG_CELL_SIZE_X: csize[0] <= (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1)
                                                                  : cfg_data[SIZE_W-1:0];
        REG_CELL_SIZE_Y: csize[1] <= (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1)
                                                                  : cfg_data[SIZE_W-1:0];
        REG_CELL_SIZE_Z: csize[2] <= (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1)
                                                                  : cfg_data[SIZE_W-1:0];
        REG_GRID_COUNTS: grid <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets, direction and distance of the selected axis
  always_comb begin
    sz   = csize[cmd.axis];
    rs   = $signed({p0[cmd.axis][COORD_W-1], p0[cmd.axis]})
         - $signed({amin[cmd.axis][COORD_W-1], amin[cmd.axis]});
    rf   = $signed({p1[cmd.axis][COORD_W-1], p1[cmd.axis]})
         - $signed({amin[cmd.axis][COORD_W-1], amin[cmd.axis]});
    d    = $signed({p1[cmd.axis][COORD_W-1], p1[cmd.axis]})
         - $signed({p0[cmd.axis][COORD_W-1], p0[cmd.axis]});
    ad   = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    dr   = WIDE_W'(rs) - $signed({2'b00, prod});
    dd   = d[COORD_W] ? dr : ($signed({{(WIDE_W-SIZE_W){1'b0}}, sz}) - dr);
    face_dist = dd[WIDE_W-1] ? '0 : dd[DIST_W-1:0];
  end

  // divider operand selection
  always_comb begin
    div_short = 1'b0;
    div_num   = '0;
    div_den   = ad;
    case (cmd.op)
      OP_START_CELL: begin
        div_short = 1'b1;
        div_num   = rs[COORD_W] ? '0 : NUM_W'(rs[COORD_W-1:0]);
        div_den   = COORD_W'(sz);
      end
      OP_FINISH_CELL: begin
        div_short = 1'b1;
        div_num   = rf[COORD_W] ? '0 : NUM_W'(rf[COORD_W-1:0]);
        div_den   = COORD_W'(sz);
      end
      OP_DELTA: div_num = NUM_W'({sz, {FRAC_BITS{1'b0}}});
      OP_EXIT:  div_num = {face_dist, {FRAC_BITS{1'b0}}};
      default: ;
    endcase
  end

  lsvw_div #(
    .NUM_W(NUM_W),
    .DEN_W(COORD_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .short_mode(div_short),
    .num       (div_num),
    .den       (div_den),
    .busy      (div_busy),
    .done      (div_done),
    .quot      (quot),
    .sat       (sat)
  );

  // saturated results of the divider
  always_comb begin
    q_eff  = sat ? '1 : quot;
    cell_q = (sat || (quot[CELL_W-1:0] > nm1[cmd.axis])) ? nm1[cmd.axis]
                                                         : quot[CELL_W-1:0];
  end

  // axis choice, ties to y or z
  always_comb begin
    if (ext[0] < ext[1]) ws = (ext[0] < ext[2]) ? AXIS_X : AXIS_Z;
    else                 ws = (ext[1] < ext[2]) ? AXIS_Y : AXIS_Z;
    cur_s = cur[ws];
    nc    = cur_s;
    if (dpos[ws] && (cur_s != nm1[ws])) nc = cur_s + CELL_W'(1);
    if (dneg[ws] && (cur_s != '0))      nc = cur_s - CELL_W'(1);
    exit_sum = {1'b0, ext[ws]} + {1'b0, dlt[ws]};
    at_end   = (cur[0] == tgt[0]) && (cur[1] == tgt[1]) && (cur[2] == tgt[2]);
    cnt_hit  = cnt == CNT_W'(MAX_STEPS - 1);
    lin      = 16'(cur[0]) * 16'(nyz) + 16'(cur[1]) * 16'(nz) + 16'(cur[2]);
  end

  // setup and walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p0[0] <= start_x;
      p0[1] <= start_y;
      p0[2] <= start_z;
      p1[0] <= finish_x;
      p1[1] <= finish_y;
      p1[2] <= finish_z;
      nz    <= axis_count(grid, AXIS_Z);
      nyz   <= (2*CELL_W)'(axis_count(grid, AXIS_Y)) * (2*CELL_W)'(axis_count(grid, AXIS_Z));
    end
    if (cmd.div_go) op_q <= cmd.op;
    if (cmd.mul_go) prod <= PROD_W'(cur[cmd.axis]) * PROD_W'(sz);
    if (cmd.set_dir) begin
      dpos[cmd.axis] <= !d[COORD_W];
      dneg[cmd.axis] <= d[COORD_W];
    end
    if (cmd.zero_axis) begin
      dpos[cmd.axis] <= 1'b0;
      dneg[cmd.axis] <= 1'b0;
      ext[cmd.axis]  <= '1;
      dlt[cmd.axis]  <= '1;
    end
    if (div_done) begin
      case (op_q)
        OP_START_CELL:  cur[cmd.axis] <= cell_q;
        OP_FINISH_CELL: tgt[cmd.axis] <= cell_q;
        OP_DELTA:       dlt[cmd.axis] <= q_eff;
        OP_EXIT:        ext[cmd.axis] <= q_eff;
        default: ;
      endcase
    end
    if (cmd.emit && !(at_end || cnt_hit)) begin
      cur[ws] <= nc;
      ext[ws] <= exit_sum[TIME_W] ? '1 : exit_sum[TIME_W-1:0];
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_x       <= cur[0][OUT_C_W-1:0];
      cell_y       <= cur[1][OUT_C_W-1:0];
      cell_z       <= cur[2][OUT_C_W-1:0];
      linear_index <= lin[LIN_W-1:0];
      last         <= at_end || cnt_hit;
      overrun      <= !at_end && cnt_hit;
    end
  end

  // status to the controller
  always_comb begin
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.d_zero   = d == '0;
    sts.at_end   = at_end;
    sts.cnt_hit  = cnt_hit;
    sts.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lsvw_ctrl.sv =====
// controller: setup sequence per axis, then the walk
`timescale 1ns / 1ps
`default_nettype none
module lsvw_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  lsvw_pkg::sts_t sts,
  output lsvw_pkg::cmd_t       cmd
);
  import lsvw_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CS   = 4'd1;
  localparam logic [3:0] S_CS_W = 4'd2;
  localparam logic [3:0] S_CF   = 4'd3;
  localparam logic [3:0] S_CF_W = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DT   = 4'd6;
  localparam logic [3:0] S_DT_W = 4'd7;
  localparam logic [3:0] S_EX   = 4'd8;
  localparam logic [3:0] S_EX_W = 4'd9;
  localparam logic [3:0] S_WALK = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] axis;
  logic [1:0] axis_next;

  // next state and commands
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    in_ready   = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_next   = AXIS_X;
          state_next  = S_CS;
        end
      end
      S_CS: begin
        cmd.div_go = 1'b1;
        cmd.op     = OP_START_CELL;
        state_next = S_CS_W;
      end
      S_CS_W: begin
        cmd.op = OP_START_CELL;
        if (sts.div_done) state_next = S_CF;
      end
      S_CF: begin
        cmd.div_go = 1'b1;
        cmd.op     = OP_FINISH_CELL;
        state_next = S_CF_W;
      end
      S_CF_W: begin
        cmd.op = OP_FINISH_CELL;
        if (sts.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_DT;
      end
      S_DT: begin
        cmd.op = OP_DELTA;
        if (sts.d_zero) begin
          // standing axis never steps
          cmd.zero_axis = 1'b1;
          if (axis == AXIS_Z) begin
            state_next = S_WALK;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = S_CS;
          end
        end else begin
          cmd.div_go  = 1'b1;
          cmd.set_dir = 1'b1;
          state_next  = S_DT_W;
        end
      end
      S_DT_W: begin
        cmd.op = OP_DELTA;
        if (sts.div_done) state_next = S_EX;
      end
      S_EX: begin
        cmd.div_go = 1'b1;
        cmd.op     = OP_EXIT;
        state_next = S_EX_W;
      end
      S_EX_W: begin
        cmd.op = OP_EXIT;
        if (sts.div_done) begin
          if (axis == AXIS_Z) begin
            state_next = S_WALK;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = S_CS;
          end
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.at_end || sts.cnt_hit) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/line_segment_voxel_walk_top.sv =====
// top level of the line segment voxel walk
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_we                cfg_index, cfg_data
//  in       in         in_valid / in_ready   start_x/y/z, finish_x/y/z
//  out      out        out_valid / out_ready cell_x/y/z, linear_index, last, overrun
//
// One segment is set up with, per axis, two 5-bit divisions for the start and end
// cells, one multiply and, if the axis moves, two 32-bit divisions for the crossing
// interval and first exit time, all on one shared shift-subtract divider. The walk
// then sends one voxel per cycle, unless a stalled output holds it, and at most
// MAX_STEPS per segment. A new segment is taken once the last voxel sits in the
// output register. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module line_segment_voxel_walk_top #(
  parameter int FRAC_BITS = lsvw_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS = lsvw_pkg::MAX_STEPS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [lsvw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [lsvw_pkg::COORD_W-1:0]    cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [lsvw_pkg::COORD_W-1:0]    start_x,
  input  wire  [lsvw_pkg::COORD_W-1:0]    start_y,
  input  wire  [lsvw_pkg::COORD_W-1:0]    start_z,
  input  wire  [lsvw_pkg::COORD_W-1:0]    finish_x,
  input  wire  [lsvw_pkg::COORD_W-1:0]    finish_y,
  input  wire  [lsvw_pkg::COORD_W-1:0]    finish_z,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [lsvw_pkg::OUT_C_W-1:0]    cell_x,
  output logic [lsvw_pkg::OUT_C_W-1:0]    cell_y,
  output logic [lsvw_pkg::OUT_C_W-1:0]    cell_z,
  output logic [lsvw_pkg::LIN_W-1:0]      linear_index,
  output logic                            last,
  output logic                            overrun
);
  import lsvw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsvw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lsvw_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .finish_x    (finish_x),
    .finish_y    (finish_y),
    .finish_z    (finish_z),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .linear_index(linear_index),
    .last        (last),
    .overrun     (overrun)
  );

  // a transfer in starts a busy period
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // divider is never restarted while running
  a_div_idle_on_go: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !sts.div_busy)
    else $error("divider started while busy");

  // a voxel is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten");

  // overrun only comes with the final voxel
  a_overrun_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && overrun |-> last)
    else $error("overrun without last");

endmodule
`default_nettype wire
